@@ rtl/ddet_pkg.sv @@
// ddet_pkg: shared types and constants of the deadlock detector
// holds word layouts, opcodes, sizes and the controller/datapath interface structs
// no dependencies
package ddet_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int PIDX_W        = 4;
    localparam int RIDX_W        = 3;
    localparam int ADDR_W        = PIDX_W + RIDX_W;
    localparam int AMT_W         = 16;
    localparam int WORK_W        = 21;
    localparam int PCNT_W        = 5;
    localparam int RCNT_W        = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 5;

    localparam logic [1:0] OP_LOAD_ALLOC   = 2'd0;
    localparam logic [1:0] OP_LOAD_REQUEST = 2'd1;
    localparam logic [1:0] OP_LOAD_AVAIL   = 2'd2;
    localparam logic [1:0] OP_START        = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PIDX_W-1:0] process_index;
        logic [RIDX_W-1:0] resource_index;
        logic [AMT_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic [PIDX_W-1:0] result_process;
        logic              is_deadlocked;
        logic              none_deadlocked;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic load;          // store the accepted load word
        logic init;          // seed work from available, clear marks and counters
        logic clr_r;
        logic inc_r;
        logic clr_p;
        logic inc_p;
        logic add_work;      // work[r] += alloc[p][r], saturating
        logic finish;        // mark process p finished and flag progress
        logic clr_progress;
        logic out_load;      // load result for process p into output register
    } ddet_cmd_t;

    typedef struct packed {
        logic marked;
        logic p_last;
        logic r_last;
        logic req_ok;
        logic progress;
        logic out_free;
    } ddet_status_t;

endpackage

@@ rtl/ddet_dp.sv @@
// ddet_dp: datapath of the deadlock detector
// holds the matrix memories, available and work vectors, marks, counters and result register
// depends on ddet_pkg
module ddet_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ddet_pkg::in_item_t                   in_data,
    input  logic                                 cfg_valid,
    input  logic [ddet_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ddet_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  ddet_pkg::ddet_cmd_t                  cmd,
    output ddet_pkg::ddet_status_t               status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ddet_pkg::out_item_t                  out_data
);
    import ddet_pkg::*;

    logic [AMT_W-1:0]  alloc_mem   [MAX_PROCESSES*MAX_RESOURCES];
    logic [AMT_W-1:0]  request_mem [MAX_PROCESSES*MAX_RESOURCES];
    logic [AMT_W-1:0]  avail_reg   [MAX_RESOURCES];
    logic [WORK_W-1:0] work_reg    [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] marks_reg;
    logic              progress_reg;
    logic [PIDX_W-1:0] p_reg;
    logic [RIDX_W-1:0] r_reg;
    logic [AMT_W-1:0]  alloc_q;
    logic [AMT_W-1:0]  request_q;
    logic [PCNT_W-1:0] pcount_reg;
    logic [RCNT_W-1:0] rcount_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [PIDX_W-1:0] pmax;
    logic [RIDX_W-1:0] rmax;
    logic [PCNT_W-1:0] pcount_m1;
    logic [RCNT_W-1:0] rcount_m1;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORK_W:0]   work_sum;
    logic [WORK_W-1:0] work_next;
    logic              none_deadlocked;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= PCNT_W'(MAX_PROCESSES);
            rcount_reg <= RCNT_W'(MAX_RESOURCES);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PROCESS_COUNT:  pcount_reg <= cfg_data[PCNT_W-1:0];
                CFG_RESOURCE_COUNT: rcount_reg <= cfg_data[RCNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // clamped counts, kept as highest index in use
    assign pcount_m1 = pcount_reg - PCNT_W'(1);
    assign rcount_m1 = rcount_reg - RCNT_W'(1);

    always_comb
    begin
        if (pcount_reg == '0)
            pmax = '0;
        else if (pcount_reg > PCNT_W'(MAX_PROCESSES))
            pmax = PIDX_W'(MAX_PROCESSES - 1);
        else
            pmax = pcount_m1[PIDX_W-1:0];

        if (rcount_reg == '0)
            rmax = '0;
        else if (rcount_reg > RCNT_W'(MAX_RESOURCES))
            rmax = RIDX_W'(MAX_RESOURCES - 1);
        else
            rmax = rcount_m1[RIDX_W-1:0];
    end

    // matrix memories: one write port for loads, one registered read port for the walk
    assign waddr = {in_data.process_index, in_data.resource_index};
    assign raddr = {p_reg, r_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.opcode == OP_LOAD_ALLOC)
            alloc_mem[waddr] <= in_data.amount;
        if (cmd.load && in_data.opcode == OP_LOAD_REQUEST)
            request_mem[waddr] <= in_data.amount;
        alloc_q   <= alloc_mem[raddr];
        request_q <= request_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.opcode == OP_LOAD_AVAIL)
            avail_reg[in_data.resource_index] <= in_data.amount;
    end

    // saturating release into work
    assign work_sum  = {1'b0, work_reg[r_reg]} + (WORK_W+1)'(alloc_q);
    assign work_next = work_sum[WORK_W] ? {WORK_W{1'b1}} : work_sum[WORK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
                work_reg[i] <= '0;
        end
        else if (cmd.init)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
                work_reg[i] <= (RIDX_W'(i) <= rmax) ? WORK_W'(avail_reg[i]) : '0;
        end
        else if (cmd.add_work)
        begin
            work_reg[r_reg] <= work_next;
        end
    end

    // marks, progress flag and walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg    <= '0;
            progress_reg <= 1'b0;
            p_reg        <= '0;
            r_reg        <= '0;
        end
        else
        begin
            if (cmd.init)
                marks_reg <= '0;
            else if (cmd.finish)
                marks_reg[p_reg] <= 1'b1;

            if (cmd.init || cmd.clr_progress)
                progress_reg <= 1'b0;
            else if (cmd.finish)
                progress_reg <= 1'b1;

            if (cmd.init || cmd.clr_p)
                p_reg <= '0;
            else if (cmd.inc_p)
                p_reg <= p_reg + PIDX_W'(1);

            if (cmd.init || cmd.clr_r)
                r_reg <= '0;
            else if (cmd.inc_r)
                r_reg <= r_reg + RIDX_W'(1);
        end
    end

    always_comb
    begin
        none_deadlocked = 1'b1;
        for (int i = 0; i < MAX_PROCESSES; i++)
            if (PIDX_W'(i) <= pmax && !marks_reg[i])
                none_deadlocked = 1'b0;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.result_process  <= p_reg;
            out_data_reg.is_deadlocked   <= ~marks_reg[p_reg];
            out_data_reg.none_deadlocked <= none_deadlocked;
            out_data_reg.last            <= (p_reg == pmax);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.marked   = marks_reg[p_reg];
    assign status.p_last   = (p_reg == pmax);
    assign status.r_last   = (r_reg == rmax);
    assign status.req_ok   = (WORK_W'(request_q) <= work_reg[r_reg]);
    assign status.progress = progress_reg;
    assign status.out_free = ~out_valid_reg | out_ready;

endmodule

@@ rtl/ddet_ctrl.sv @@
// ddet_ctrl: controller state machine of the deadlock detector
// sequences loads, detection passes and result output through command words
// depends on ddet_pkg
module ddet_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  ddet_pkg::ddet_status_t status,
    output ddet_pkg::ddet_cmd_t    cmd
);
    import ddet_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT     = 4'd1;
    localparam logic [3:0] ST_SEL      = 4'd2;
    localparam logic [3:0] ST_RD_REQ   = 4'd3;
    localparam logic [3:0] ST_CMP_REQ  = 4'd4;
    localparam logic [3:0] ST_RD_ALLOC = 4'd5;
    localparam logic [3:0] ST_ADD      = 4'd6;
    localparam logic [3:0] ST_NEXT     = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_START)
                        state_next = ST_INIT;
                    else
                        cmd.load = 1'b1;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                state_next = status.marked ? ST_NEXT : ST_RD_REQ;
            end
            ST_RD_REQ:
            begin
                state_next = ST_CMP_REQ;
            end
            ST_CMP_REQ:
            begin
                if (!status.req_ok)
                    state_next = ST_NEXT;
                else if (status.r_last)
                begin
                    cmd.clr_r  = 1'b1;
                    state_next = ST_RD_ALLOC;
                end
                else
                begin
                    cmd.inc_r  = 1'b1;
                    state_next = ST_RD_REQ;
                end
            end
            ST_RD_ALLOC:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_work = 1'b1;
                if (status.r_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.inc_r  = 1'b1;
                    state_next = ST_RD_ALLOC;
                end
            end
            ST_NEXT:
            begin
                cmd.clr_r = 1'b1;
                if (status.p_last)
                begin
                    cmd.clr_p = 1'b1;
                    if (status.progress)
                    begin
                        cmd.clr_progress = 1'b1;
                        state_next       = ST_SEL;
                    end
                    else
                        state_next = ST_OUT;
                end
                else
                begin
                    cmd.inc_p  = 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.p_last)
                        state_next = ST_IDLE;
                    else
                        cmd.inc_p = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/deadlock_detector.sv @@
// deadlock_detector: load words are taken back to back while idle, no result
// start word: an init state, then per pass and process the select and next states, per request
//   compared read and compare, per allocation released read and add (one registered matrix
//   read each), then one result word per cycle per process in use while the output is taken
// async active-low reset: counts back to 16 processes and 8 resources, work and marks cleared,
//   matrix and available stores hold nothing defined until loaded
module deadlock_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ddet_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ddet_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ddet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddet_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ddet_pkg::*;

    // command and status words between controller and datapath
    ddet_cmd_t    cmd;
    ddet_status_t status;

    // configuration writes are registered on acceptance, never stall
    assign cfg_ready = 1'b1;

    // controller: walks processes and resources one memory read at a time
    ddet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (in_data.opcode),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: matrix memories, work vector, finish marks and result register
    ddet_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a process is released at most once per detection
    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.marked)
        else $error("finished process released again");

    // a pending result word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while pending");

    // global flag agrees with the per-process flag
    a_none_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.none_deadlocked) |-> !out_data.is_deadlocked)
        else $error("none_deadlocked set on a deadlocked process");

endmodule

@@ bench/ddet_checker.sv @@
// ddet_checker: watches the word, result and register channels of the deadlock detector,
// predicts the result words of every start and compares them; depends on ddet_pkg
`timescale 1ns / 1ps
module ddet_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  ddet_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  ddet_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ddet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddet_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import ddet_pkg::*;

    localparam logic [WORK_W-1:0] WORK_LIMIT = '1;

    // mirror of the loaded matrices and vector
    logic [AMT_W-1:0]  alloc_mem [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMT_W-1:0]  req_mem   [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMT_W-1:0]  avail_mem [MAX_RESOURCES];
    logic [PCNT_W-1:0] proc_count;
    logic [RCNT_W-1:0] res_count;

    out_item_t verdict_q [$];

    // safety pass over the processes in use, queues one verdict per process
    task automatic detect_deadlocks();
        int                np;
        int                nr;
        logic              progress;
        logic              fits;
        logic              all_done;
        logic [WORK_W:0]   sum;
        logic [WORK_W-1:0] work [MAX_RESOURCES];
        logic [MAX_PROCESSES-1:0] finished;
        out_item_t         v;

        np = (proc_count == '0) ? 1 :
             ((int'(proc_count) > MAX_PROCESSES) ? MAX_PROCESSES : int'(proc_count));
        nr = (res_count == '0) ? 1 :
             ((int'(res_count) > MAX_RESOURCES) ? MAX_RESOURCES : int'(res_count));
        for (int r = 0; r < MAX_RESOURCES; r++)
            work[r] = (r < nr) ? {{(WORK_W-AMT_W){1'b0}}, avail_mem[r]} : '0;
        finished = '0;
        progress = 1'b1;
        while (progress)
        begin
            progress = 1'b0;
            for (int p = 0; p < np; p++)
            begin
                if (!finished[p])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < nr; r++)
                        if (req_mem[p][r] > work[r])
                            fits = 1'b0;
                    if (fits)
                    begin
                        for (int r = 0; r < nr; r++)
                        begin
                            sum = {1'b0, work[r]} + {{(WORK_W+1-AMT_W){1'b0}}, alloc_mem[p][r]};
                            work[r] = (sum > {1'b0, WORK_LIMIT}) ? WORK_LIMIT : sum[WORK_W-1:0];
                        end
                        finished[p] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        all_done = 1'b1;
        for (int p = 0; p < np; p++)
            if (!finished[p])
                all_done = 1'b0;
        for (int p = 0; p < np; p++)
        begin
            v.result_process  = PIDX_W'(p);
            v.is_deadlocked   = !finished[p];
            v.none_deadlocked = all_done;
            v.last            = (p == np - 1);
            verdict_q.push_back(v);
        end
    endtask

    function automatic int field_differs(input string name, input logic [3:0] want,
                                         input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            verdict_q.delete();
            proc_count = PCNT_W'(MAX_PROCESSES);
            res_count  = RCNT_W'(MAX_RESOURCES);
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected nothing got process %0d",
                             $time, out_data.result_process);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    mismatches = mismatches
                        + field_differs("result_process", want.result_process,
                                        out_data.result_process)
                        + field_differs("is_deadlocked", {3'b000, want.is_deadlocked},
                                        {3'b000, out_data.is_deadlocked})
                        + field_differs("none_deadlocked", {3'b000, want.none_deadlocked},
                                        {3'b000, out_data.none_deadlocked})
                        + field_differs("last", {3'b000, want.last}, {3'b000, out_data.last});
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PROCESS_COUNT)
                    proc_count = cfg_data[PCNT_W-1:0];
                else
                    res_count = cfg_data[RCNT_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                case (in_data.opcode)
                    OP_LOAD_ALLOC:
                        alloc_mem[in_data.process_index][in_data.resource_index] = in_data.amount;
                    OP_LOAD_REQUEST:
                        req_mem[in_data.process_index][in_data.resource_index] = in_data.amount;
                    OP_LOAD_AVAIL:
                        avail_mem[in_data.resource_index] = in_data.amount;
                    default:
                        detect_deadlocks();
                endcase
            end
            pending <= verdict_q.size();
        end
    end

endmodule

@@ bench/tb_deadlock_detector.sv @@
// tb_deadlock_detector: clock, reset, directed and random words and the final verdict
// depends on ddet_pkg, deadlock_detector and ddet_checker
`timescale 1ns / 1ps
module tb_deadlock_detector;
    import ddet_pkg::*;

    localparam int TOTAL_WORDS   = 330;
    localparam int LONG_HOLD     = 400;   // receiver hold-off, long enough to back up the input
    localparam int SETTLE_CYCLES = 8;     // a trailing load word may still be in flight
    localparam int DRAIN_CYCLES  = 24;
    localparam int LIMIT_NS      = 20_000_000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    mismatches;
    int                    pending;

    // hold-off requests from the sender side, served by the receiver process
    int hold_asked = 0;
    int hold_done  = 0;

    // every word accepted so far, directed, fill and random alike
    int words_sent = 0;

    // which store entries have been loaded, so no start reads an empty one
    logic alloc_set [MAX_PROCESSES][MAX_RESOURCES];
    logic req_set   [MAX_PROCESSES][MAX_RESOURCES];
    logic avail_set [MAX_RESOURCES];

    // counts in use after clamping, as the sender last programmed them
    int procs_used = MAX_PROCESSES;
    int res_used   = MAX_RESOURCES;

    // remaining cycles of a no-idle stretch on each side
    int in_calm  = 0;
    int out_calm = 0;

    deadlock_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ddet_checker verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly no gap, some short, a few long, and now and then a stretch with none at all
    task automatic pick_gap(inout int calm, output int gap);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm = calm - 1;
            gap = 0;
        end
        else if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            gap = 0;
        end
        else if (r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
    endtask

    // small counts dominate so requests and work land close together
    function automatic logic [AMT_W-1:0] pick_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return AMT_W'($urandom_range(0, 6));
        if (r < 78)
            return AMT_W'($urandom_range(0, 40));
        if (r < 90)
            return AMT_W'($urandom);
        if (r < 95)
            return '1;
        return '0;
    endfunction

    function automatic int in_use(input int v, input int lim);
        return (v == 0) ? 1 : ((v > lim) ? lim : v);
    endfunction

    // valid stays up after acceptance; the next call either reloads it or drops it,
    // so there is never more than one update of in_valid per edge
    task automatic send_word(input in_item_t w);
        int gap;
        pick_gap(in_calm, gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent = words_sent + 1;
    endtask

    task automatic load(input logic [1:0] op, input int p, input int r,
                        input logic [AMT_W-1:0] amt);
        in_item_t w;
        w.opcode         = op;
        w.process_index  = PIDX_W'(p);
        w.resource_index = RIDX_W'(r);
        w.amount         = amt;
        send_word(w);
        if (op == OP_LOAD_ALLOC)
            alloc_set[p][r] = 1'b1;
        else if (op == OP_LOAD_REQUEST)
            req_set[p][r] = 1'b1;
        else
            avail_set[r] = 1'b1;
    endtask

    // start word, the ignored fields carry random bits
    task automatic start_detection();
        in_item_t w;
        w.opcode         = OP_START;
        w.process_index  = PIDX_W'($urandom);
        w.resource_index = RIDX_W'($urandom);
        w.amount         = AMT_W'($urandom);
        send_word(w);
    endtask

    // mostly inside the counts in use, some noise anywhere in the stores
    task automatic random_load();
        int         sel;
        int         p;
        int         r;
        logic [1:0] op;
        sel = $urandom_range(0, 2);
        op = (sel == 0) ? OP_LOAD_ALLOC : ((sel == 1) ? OP_LOAD_REQUEST : OP_LOAD_AVAIL);
        if ($urandom_range(0, 7) != 0)
        begin
            p = $urandom_range(0, procs_used - 1);
            r = $urandom_range(0, res_used - 1);
        end
        else
        begin
            p = $urandom_range(0, MAX_PROCESSES - 1);
            r = $urandom_range(0, MAX_RESOURCES - 1);
        end
        load(op, p, r, pick_amount());
    endtask

    // load every entry the next start will read that has never been loaded
    task automatic fill_needed();
        for (int p = 0; p < procs_used; p++)
            for (int r = 0; r < res_used; r++)
            begin
                if (!alloc_set[p][r])
                    load(OP_LOAD_ALLOC, p, r, pick_amount());
                if (!req_set[p][r])
                    load(OP_LOAD_REQUEST, p, r, pick_amount());
            end
        for (int r = 0; r < res_used; r++)
            if (!avail_set[r])
                load(OP_LOAD_AVAIL, $urandom_range(0, MAX_PROCESSES - 1), r, pick_amount());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int gap;
        pick_gap(in_calm, gap);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only with nothing in flight; a negative count is left alone
    task automatic reconfigure(input int pc, input int rc);
        logic [CFG_DATA_W-1:0] val;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pc >= 0)
        begin
            val = CFG_DATA_W'(pc);
            write_reg(CFG_PROCESS_COUNT, val);
            procs_used = in_use(int'(val[PCNT_W-1:0]), MAX_PROCESSES);
        end
        if (rc >= 0)
        begin
            // the top data bit is beyond the resource register
            val = {1'($urandom_range(0, 1)), rc[RCNT_W-1:0]};
            write_reg(CFG_RESOURCE_COUNT, val);
            res_used = in_use(int'(val[RCNT_W-1:0]), MAX_RESOURCES);
        end
    endtask

    // receiver: random stalls, plus the long hold-offs the sender asks for
    initial
    begin : receiver
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_done != hold_asked)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = hold_done + 1;
            end
            else
            begin
                pick_gap(out_calm, gap);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int pc;
        int rc;
        int n;
        int sel;

        for (int p = 0; p < MAX_PROCESSES; p++)
            for (int r = 0; r < MAX_RESOURCES; r++)
            begin
                alloc_set[p][r] = 1'b0;
                req_set[p][r]   = 1'b0;
            end
        for (int r = 0; r < MAX_RESOURCES; r++)
            avail_set[r] = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two processes on one resource
        reconfigure(2, 1);
        load(OP_LOAD_ALLOC, 0, 0, '1);
        load(OP_LOAD_ALLOC, 1, 0, '0);
        load(OP_LOAD_REQUEST, 0, 0, '0);
        load(OP_LOAD_REQUEST, 1, 0, '1);
        load(OP_LOAD_AVAIL, 0, 0, '0);
        // process 0 frees a full allocation, process 1 then fits exactly
        start_detection();
        // too little released for process 1, it stays deadlocked
        load(OP_LOAD_ALLOC, 0, 0, 5);
        start_detection();
        // top row and column loads; all but the available word land outside the counts in use
        load(OP_LOAD_AVAIL, MAX_PROCESSES - 1, 0, '1);
        load(OP_LOAD_ALLOC, MAX_PROCESSES - 1, MAX_RESOURCES - 1, '1);
        load(OP_LOAD_REQUEST, MAX_PROCESSES - 1, MAX_RESOURCES - 1, '0);
        send_word({OP_START, {PIDX_W{1'b1}}, {RIDX_W{1'b1}}, {AMT_W{1'b1}}});
        // zero counts act as one process and one resource
        reconfigure(0, 0);
        load(OP_LOAD_AVAIL, 0, 0, 100);
        load(OP_LOAD_REQUEST, 0, 0, 101);
        start_detection();

        // random phases: optional reconfiguration, a burst of loads, then a start;
        // the phases with the long hold-off always run
        phase = 0;
        while (words_sent < TOTAL_WORDS || phase <= 5)
        begin
            if (phase == 2)
                // counts above range clamp to the full matrices
                reconfigure(31, 15);
            else if (phase == 9)
                reconfigure(MAX_PROCESSES, MAX_RESOURCES);
            else if (phase == 0 || (phase != 5 && $urandom_range(0, 3) == 0))
            begin
                sel = $urandom_range(0, 99);
                pc = (sel < 70) ? $urandom_range(1, 6) :
                     (sel < 80) ? $urandom_range(7, MAX_PROCESSES) :
                     (sel < 88) ? MAX_PROCESSES :
                     (sel < 94) ? $urandom_range(MAX_PROCESSES + 1, 31) : 0;
                sel = $urandom_range(0, 99);
                rc = (sel < 70) ? $urandom_range(1, 4) :
                     (sel < 82) ? $urandom_range(5, MAX_RESOURCES) :
                     (sel < 90) ? $urandom_range(MAX_RESOURCES + 1, 15) : 0;
                // sometimes only one of the two registers moves
                sel = $urandom_range(0, 3);
                if (phase != 0 && sel == 0)
                    pc = -1;
                else if (phase != 0 && sel == 1)
                    rc = -1;
                reconfigure(pc, rc);
            end

            // the receiver goes quiet while this phase and the next keep offering words
            if (phase == 4)
                hold_asked <= hold_asked + 1;

            n = $urandom_range(0, 10);
            repeat (n) random_load();
            // an occasional phase ends without a start
            if (phase == 4 || $urandom_range(0, 7) != 0)
            begin
                fill_needed();
                start_detection();
                if ($urandom_range(0, 3) == 0)
                    start_detection();
            end
            phase = phase + 1;
        end

        // drain, then the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
